// ===== design/sobel_gradient_direction_defines.svh =====
`ifndef SOBEL_GRADIENT_DIRECTION_DEFINES_SVH
`define SOBEL_GRADIENT_DIRECTION_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define SGD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that holds in the cycle after its trigger.
`define SGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sgd_pkg.sv =====
`timescale 1ns / 1ps

package sgd_pkg;

   // Fixed field widths of the item channels and the register port
   localparam int PIXEL_IN_BITS  = 8;
   localparam int MAG_BITS       = 11;
   localparam int DIR_BITS       = 3;
   localparam int ROW_BITS       = 11;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // Register reset values and limits
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int HEIGHT_LIMIT = 1024;

   // Sector bounds: tan(22.5) and tan(67.5) in Q16
   localparam int TAN_FRAC_BITS = 16;
   localparam int TAN_LOW_BITS  = 15;
   localparam int TAN_HIGH_BITS = 18;
   localparam logic [TAN_LOW_BITS-1:0]  TAN_LOW_Q16  = 15'd27146;
   localparam logic [TAN_HIGH_BITS-1:0] TAN_HIGH_Q16 = 18'd158218;

   localparam logic [MAG_BITS-1:0] MAG_MAX = 11'd2047;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_NONE       = 3'd0,
      DIR_HORIZONTAL = 3'd1,
      DIR_SLASH      = 3'd2,
      DIR_VERTICAL   = 3'd3,
      DIR_BACKSLASH  = 3'd4
   } sgd_dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAD,
      ST_MULT,
      ST_PREP,
      ST_ROOT,
      ST_HOLD
   } sgd_state_type;

   typedef struct packed {
      logic [PIXEL_IN_BITS-1:0] pixel;
      logic                     flush;
   } sgd_req_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] magnitude;
      logic [DIR_BITS-1:0] direction;
      logic                last_of_frame;
   } sgd_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;     // item taken: read line stores, latch pixel
      logic step;        // gradients, store write-back, window and counter update
      logic mult;        // squares and tangent products
      logic root_start;  // direction code, launch square root
      logic load;        // move result into the output register
   } sgd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic ignore;      // flush arriving while the frame is still coming in
      logic emit;        // current item produces a result
      logic root_busy;   // square root unit iterating
      logic out_free;    // output register can take a result this cycle
   } sgd_status_type;

endpackage

// ===== design/sgd_ctrl.sv =====
`timescale 1ns / 1ps
`include "sobel_gradient_direction_defines.svh"

module sgd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sgd_pkg::sgd_status_type status,
   output sgd_pkg::sgd_cmd_type    cmd
);
   import sgd_pkg::*;

   sgd_state_type state_ff;
   sgd_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.ignore) state_in = ST_GRAD;
         end
         ST_GRAD: begin
            state_in = status.emit ? ST_MULT : ST_IDLE;
         end
         ST_MULT: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!status.root_busy) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid && !status.ignore;
         end
         ST_GRAD: begin
            cmd.step = 1'b1;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_PREP: begin
            cmd.root_start = 1'b1;
         end
         ST_HOLD: begin
            cmd.load = status.out_free;
         end
         default: begin
         end
      endcase
   end

   // Square root unit is free when launched, and runs right after
   `SGD_ASSERT_NOW(a_root_free, clock, reset, cmd.root_start, !status.root_busy, "root unit busy at start")
   `SGD_ASSERT_NEXT(a_root_runs, clock, reset, cmd.root_start, status.root_busy, "root unit did not start")
   // Only items that produce a result reach the multiply step
   `SGD_ASSERT_NOW(a_mult_emit, clock, reset, state_ff == ST_MULT, $past(status.emit), "mult without result")

endmodule

// ===== design/sgd_isqrt.sv =====
`timescale 1ns / 1ps

// Restoring digit-by-digit square root, one result bit per cycle.
module sgd_isqrt #(
   parameter int RAD_BITS = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [RAD_BITS-1:0]            radicand,
   output logic                           busy,
   output logic [(RAD_BITS+1)/2-1:0]      root
);
   localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int SHIFT_BITS = 2 * ROOT_BITS;
   localparam int CNT_BITS   = $clog2(ROOT_BITS + 1);

   logic                  busy_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [SHIFT_BITS-1:0] rad_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [ROOT_BITS-1:0]  root_ff;

   logic [REM_BITS-1:0]   rem_shift;
   logic [REM_BITS-1:0]   trial;
   logic                  fits;
   logic [REM_BITS-1:0]   rem_in;
   logic [ROOT_BITS-1:0]  root_in;

   // One iteration: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_shift = {rem_ff[REM_BITS-3:0], rad_ff[SHIFT_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      fits      = rem_shift >= trial;
      rem_in    = fits ? (rem_shift - trial) : rem_shift;
      root_in   = {root_ff[ROOT_BITS-2:0], fits};
   end

   // Control: busy flag and iteration count
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_BITS'(ROOT_BITS);
      end else if (busy_ff) begin
         if (count_ff == CNT_BITS'(1)) busy_ff <= 1'b0;
         count_ff <= count_ff - CNT_BITS'(1);
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= SHIFT_BITS'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== design/sgd_datapath.sv =====
`timescale 1ns / 1ps

module sgd_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sgd_pkg::sgd_req_type                  req_data,
   input  logic                                  csr_write_en,
   input  logic [sgd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sgd_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  sgd_pkg::sgd_cmd_type                  cmd,
   output sgd_pkg::sgd_status_type               status,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output sgd_pkg::sgd_rsp_type                  rsp_data
);
   import sgd_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int SUM_BITS  = PIXEL_BITS + 2;
   localparam int DIFF_BITS = PIXEL_BITS + 3;
   localparam int SQ_BITS   = 2 * SUM_BITS;
   localparam int RAD_BITS  = SQ_BITS + 1;
   localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
   localparam int LOW_BITS  = SUM_BITS + TAN_LOW_BITS;
   localparam int HIGH_BITS = SUM_BITS + TAN_HIGH_BITS;
   localparam int WIDTH_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   // Column of three pixels: [0] top, [1] middle, [2] bottom
   typedef logic [2:0][PIXEL_BITS-1:0] col_type;

   // Line stores
   logic [PIXEL_BITS-1:0] upper_row_mem  [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] middle_row_mem [MAX_WIDTH];

   // Frame position and geometry
   logic [WID_BITS-1:0]   width_ff;
   logic [ROW_BITS-1:0]   height_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;
   col_type               win0_ff;
   col_type               win1_ff;

   // Item pipeline
   logic [PIXEL_BITS-1:0] pix_ff;
   logic [PIXEL_BITS-1:0] upper_rd_ff;
   logic [PIXEL_BITS-1:0] middle_rd_ff;
   logic [SUM_BITS-1:0]   abs_x_ff;
   logic [SUM_BITS-1:0]   abs_y_ff;
   logic                  same_ff;
   logic                  last_ff;
   logic [SQ_BITS-1:0]    xx_ff;
   logic [SQ_BITS-1:0]    yy_ff;
   logic [LOW_BITS-1:0]   low_ff;
   logic [HIGH_BITS-1:0]  high_ff;
   sgd_dir_type           dir_ff;
   logic                  rsp_valid_ff;
   sgd_rsp_type           rsp_data_ff;

   // Combinational
   logic [WID_BITS-1:0]   width_wr;
   logic [ROW_BITS-1:0]   height_wr;
   logic                  cfg_hit;
   col_type               new_col;
   col_type               left_col;
   col_type               right_col;
   logic                  emit;
   logic                  last_in;
   logic                  end_frame;
   logic [SUM_BITS-1:0]   sum_left;
   logic [SUM_BITS-1:0]   sum_right;
   logic [SUM_BITS-1:0]   sum_top;
   logic [SUM_BITS-1:0]   sum_bottom;
   logic [DIFF_BITS-1:0]  gx;
   logic [DIFF_BITS-1:0]  gy;
   logic [DIFF_BITS-1:0]  abs_gx;
   logic [DIFF_BITS-1:0]  abs_gy;
   logic                  gx_pos;
   logic                  gy_pos;
   logic [COL_BITS:0]     col_inc;
   logic                  wrap;
   logic [COL_BITS-1:0]   col_in;
   logic [ROW_BITS-1:0]   row_in;
   logic [HIGH_BITS-1:0]  y_scaled;
   sgd_dir_type           dir_in;
   logic [RAD_BITS-1:0]   radicand;
   logic                  root_busy;
   logic [ROOT_BITS-1:0]  root;
   logic [MAG_BITS-1:0]   mag;

   // Register write decode with range clamping
   always_comb begin
      if (csr_wdata == '0) begin
         width_wr = WID_BITS'(1);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         width_wr = WID_BITS'(MAX_WIDTH);
      end else begin
         width_wr = WID_BITS'(csr_wdata);
      end
      if (csr_wdata == '0) begin
         height_wr = ROW_BITS'(1);
      end else if (32'(csr_wdata) > HEIGHT_LIMIT) begin
         height_wr = ROW_BITS'(HEIGHT_LIMIT);
      end else begin
         height_wr = ROW_BITS'(csr_wdata);
      end
      case (csr_index)
         REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = csr_write_en;
         default:                           cfg_hit = 1'b0;
      endcase
   end

   // Window assembly: rows above the image and pixels past the last row read as zero
   always_comb begin
      new_col[0] = (row_ff >= ROW_BITS'(2)) ? upper_rd_ff : '0;
      new_col[1] = (row_ff >= ROW_BITS'(1)) ? middle_rd_ff : '0;
      new_col[2] = (row_ff < height_ff) ? pix_ff : '0;
      end_frame  = row_ff > height_ff;
      if (col_ff == '0) begin
         // Row wrap: result for the last pixel of the previous row
         left_col  = (width_ff >= WID_BITS'(2)) ? win1_ff : '0;
         right_col = '0;
         emit      = row_ff >= ROW_BITS'(2);
         last_in   = row_ff == height_ff + ROW_BITS'(1);
      end else begin
         left_col  = (col_ff >= COL_BITS'(2)) ? win1_ff : '0;
         right_col = new_col;
         emit      = (row_ff >= ROW_BITS'(1)) && (row_ff <= height_ff);
         last_in   = 1'b0;
      end
   end

   // Sobel gradients and their magnitudes
   always_comb begin
      sum_left   = SUM_BITS'(left_col[0]) + (SUM_BITS'(left_col[1]) << 1)
                 + SUM_BITS'(left_col[2]);
      sum_right  = SUM_BITS'(right_col[0]) + (SUM_BITS'(right_col[1]) << 1)
                 + SUM_BITS'(right_col[2]);
      sum_top    = SUM_BITS'(left_col[0]) + (SUM_BITS'(win0_ff[0]) << 1)
                 + SUM_BITS'(right_col[0]);
      sum_bottom = SUM_BITS'(left_col[2]) + (SUM_BITS'(win0_ff[2]) << 1)
                 + SUM_BITS'(right_col[2]);
      gx     = DIFF_BITS'(sum_left) - DIFF_BITS'(sum_right);
      gy     = DIFF_BITS'(sum_top) - DIFF_BITS'(sum_bottom);
      abs_gx = gx[DIFF_BITS-1] ? (-gx) : gx;
      abs_gy = gy[DIFF_BITS-1] ? (-gy) : gy;
      gx_pos = !gx[DIFF_BITS-1] && (gx != '0);
      gy_pos = !gy[DIFF_BITS-1] && (gy != '0);
   end

   // Raster position advance
   always_comb begin
      col_inc = {1'b0, col_ff} + (COL_BITS+1)'(1);
      wrap    = col_inc >= (COL_BITS+1)'(width_ff);
      col_in  = wrap ? '0 : col_inc[COL_BITS-1:0];
      row_in  = wrap ? (row_ff + ROW_BITS'(1)) : row_ff;
   end

   // Sector from tangent comparisons
   always_comb begin
      y_scaled = HIGH_BITS'({abs_y_ff, {TAN_FRAC_BITS{1'b0}}});
      if (abs_x_ff == '0 && abs_y_ff == '0) begin
         dir_in = DIR_NONE;
      end else if (y_scaled <= HIGH_BITS'(low_ff)) begin
         dir_in = DIR_HORIZONTAL;
      end else if (y_scaled > high_ff) begin
         dir_in = DIR_VERTICAL;
      end else begin
         dir_in = same_ff ? DIR_SLASH : DIR_BACKSLASH;
      end
   end

   assign radicand = RAD_BITS'(xx_ff) + RAD_BITS'(yy_ff);
   assign mag = (root > ROOT_BITS'(MAG_MAX)) ? MAG_MAX : root[MAG_BITS-1:0];

   sgd_isqrt #(
      .RAD_BITS (RAD_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (radicand),
      .busy     (root_busy),
      .root     (root)
   );

   // Control state: geometry, position, window, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WID_BITS'(WIDTH_RST);
         height_ff    <= ROW_BITS'(RESET_HEIGHT);
         col_ff       <= '0;
         row_ff       <= '0;
         win0_ff      <= '0;
         win1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_hit) begin
            // A register write restarts the frame
            case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= width_wr;
               REG_IMAGE_HEIGHT: height_ff <= height_wr;
               default: begin
               end
            endcase
            col_ff  <= '0;
            row_ff  <= '0;
            win0_ff <= '0;
            win1_ff <= '0;
         end else if (cmd.step) begin
            if (end_frame) begin
               col_ff  <= '0;
               row_ff  <= '0;
               win0_ff <= '0;
               win1_ff <= '0;
            end else begin
               col_ff  <= col_in;
               row_ff  <= row_in;
               win0_ff <= new_col;
               win1_ff <= win0_ff;
            end
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Line stores: read on capture, write back in the next cycle at the same column
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         upper_rd_ff  <= upper_row_mem[col_ff];
         middle_rd_ff <= middle_row_mem[col_ff];
         pix_ff       <= PIXEL_BITS'(req_data.pixel);
      end
      if (cmd.step && !end_frame) begin
         upper_row_mem[col_ff]  <= middle_rd_ff;
         middle_row_mem[col_ff] <= new_col[2];
      end
   end

   // Item payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         abs_x_ff <= abs_gx[SUM_BITS-1:0];
         abs_y_ff <= abs_gy[SUM_BITS-1:0];
         same_ff  <= gx_pos == gy_pos;
         last_ff  <= last_in;
      end
      if (cmd.mult) begin
         xx_ff   <= SQ_BITS'(abs_x_ff) * SQ_BITS'(abs_x_ff);
         yy_ff   <= SQ_BITS'(abs_y_ff) * SQ_BITS'(abs_y_ff);
         low_ff  <= LOW_BITS'(abs_x_ff) * LOW_BITS'(TAN_LOW_Q16);
         high_ff <= HIGH_BITS'(abs_x_ff) * HIGH_BITS'(TAN_HIGH_Q16);
      end
      if (cmd.root_start) begin
         dir_ff <= dir_in;
      end
      if (cmd.load) begin
         rsp_data_ff.magnitude     <= mag;
         rsp_data_ff.direction     <= dir_ff;
         rsp_data_ff.last_of_frame <= last_ff;
      end
   end

   // Status to the controller
   always_comb begin
      status.ignore    = req_data.flush && (row_ff < height_ff);
      status.emit      = emit;
      status.root_busy = root_busy;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/sobel_gradient_direction.sv =====
`timescale 1ns / 1ps

// Streaming 3x3 Sobel gradient with magnitude and four-sector direction.
// Pixels enter in raster order; the result for a pixel leaves once the pixel
// one row and one column later has been taken, so after a frame's last pixel
// image_width + 1 flush items drain the final results (the very last one has
// last_of_frame set). Pixels outside the image count as zero. One item is
// worked on at a time: one that yields a result passes the gradient,
// multiply, prepare and bit-per-cycle square root steps; one that yields
// none ends after the gradient step, and a flush before the frame is
// complete is dropped when taken. A finished result waits in the output
// register while the next item is taken. Writing either register restarts
// the frame; width 0 acts as 1 and is capped at MAX_WIDTH, height 0 acts as 1
// and is capped at 1024. Line-store contents need no clearing after reset.
module sobel_gradient_direction #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sgd_pkg::sgd_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sgd_pkg::sgd_rsp_type                rsp_data,
   input  logic                                csr_write_en,
   input  logic [sgd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sgd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sgd_pkg::*;

   sgd_cmd_type    cmd;
   sgd_status_type status;

   sgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== test/tb_sobel_gradient_direction.sv =====
`timescale 1ns / 1ps

// Tracks the Sobel window and line stores, predicts each gradient result
// and compares the block's results against it in order.
class gradient_scoreboard;
   localparam int LINE_DEPTH = 1024;

   bit [sgd_pkg::CSR_DATA_BITS-1:0] width_reg;
   bit [sgd_pkg::CSR_DATA_BITS-1:0] height_reg;
   bit [7:0]                        upper_line [LINE_DEPTH];
   bit [7:0]                        middle_line [LINE_DEPTH];
   // columns packed as {top, middle, bottom}
   bit [23:0]                       near_col;
   bit [23:0]                       far_col;
   int unsigned                     col_pos;
   int unsigned                     row_pos;
   sgd_pkg::sgd_rsp_type            pending_gradients [$];
   int unsigned                     mismatches;

   function new();
      width_reg  = sgd_pkg::RESET_WIDTH;
      height_reg = sgd_pkg::RESET_HEIGHT;
      mismatches = 0;
      restart_frame();
   endfunction

   function void restart_frame();
      near_col = '0;
      far_col  = '0;
      col_pos  = 0;
      row_pos  = 0;
   endfunction

   function void set_register(logic [sgd_pkg::CSR_INDEX_BITS-1:0] idx,
                              logic [sgd_pkg::CSR_DATA_BITS-1:0] value);
      if (idx == sgd_pkg::REG_IMAGE_WIDTH) begin
         width_reg = value;
      end else if (idx == sgd_pkg::REG_IMAGE_HEIGHT) begin
         height_reg = value;
      end
      restart_frame();
   endfunction

   // Magnitude and sector for one 3x3 neighborhood
   function sgd_pkg::sgd_rsp_type sobel_at(bit [23:0] lc, bit [23:0] cc, bit [23:0] rc,
                                           bit last);
      int                   gx;
      int                   gy;
      int                   a;
      int                   b;
      int                   sum;
      int unsigned          root;
      int unsigned          trial;
      longint               b_scaled;
      sgd_pkg::sgd_rsp_type res;
      gx = (int'(lc[23:16]) + 2 * int'(lc[15:8]) + int'(lc[7:0]))
         - (int'(rc[23:16]) + 2 * int'(rc[15:8]) + int'(rc[7:0]));
      gy = (int'(lc[23:16]) + 2 * int'(cc[23:16]) + int'(rc[23:16]))
         - (int'(lc[7:0]) + 2 * int'(cc[7:0]) + int'(rc[7:0]));
      a = (gx < 0) ? -gx : gx;
      b = (gy < 0) ? -gy : gy;
      sum = a * a + b * b;
      // integer square root, one bit at a time from the top
      root = 0;
      for (int k = 11; k >= 0; k--) begin
         trial = root | (1 << k);
         if (trial * trial <= sum) root = trial;
      end
      if (root > sgd_pkg::MAG_MAX) root = sgd_pkg::MAG_MAX;
      res.magnitude = root[sgd_pkg::MAG_BITS-1:0];
      b_scaled = longint'(b) << sgd_pkg::TAN_FRAC_BITS;
      if (a == 0 && b == 0) begin
         res.direction = sgd_pkg::DIR_NONE;
      end else if (b_scaled <= longint'(a) * longint'(sgd_pkg::TAN_LOW_Q16)) begin
         res.direction = sgd_pkg::DIR_HORIZONTAL;
      end else if (b_scaled > longint'(a) * longint'(sgd_pkg::TAN_HIGH_Q16)) begin
         res.direction = sgd_pkg::DIR_VERTICAL;
      end else if ((gx > 0) == (gy > 0)) begin
         res.direction = sgd_pkg::DIR_SLASH;
      end else begin
         res.direction = sgd_pkg::DIR_BACKSLASH;
      end
      res.last_of_frame = last;
      return res;
   endfunction

   // Advance the stream position by one accepted item
   function void note_pixel_item(sgd_pkg::sgd_req_type item);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      bit [23:0]   fresh;
      bit [7:0]    top;
      bit [7:0]    mid;
      bit [7:0]    bot;
      w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
      h = (height_reg == 0) ? 1 :
          ((height_reg > sgd_pkg::HEIGHT_LIMIT) ? sgd_pkg::HEIGHT_LIMIT : height_reg);
      c = col_pos;
      r = row_pos;
      // flush while the frame is still coming in is dropped
      if (r < h && item.flush) return;
      if (c >= w) c = w - 1;
      top = (r >= 2) ? upper_line[c] : 8'd0;
      mid = (r >= 1) ? middle_line[c] : 8'd0;
      bot = (r < h) ? item.pixel : 8'd0;
      fresh = {top, mid, bot};
      // right edge of the previous row, or the pixel one column back
      if (c == 0) begin
         if (r >= 2) begin
            pending_gradients.push_back(sobel_at((w >= 2) ? far_col : 24'd0, near_col,
                                                 24'd0, r == h + 1));
         end
      end else if (r >= 1 && r - 1 < h) begin
         pending_gradients.push_back(sobel_at((c >= 2) ? far_col : 24'd0, near_col,
                                              fresh, 1'b0));
      end
      if (r >= h + 1) begin
         restart_frame();
         return;
      end
      upper_line[c]  = middle_line[c];
      middle_line[c] = bot;
      far_col        = near_col;
      near_col       = fresh;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function void flag(string field, logic [10:0] want, logic [10:0] got);
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endfunction

   function void check_gradient(sgd_pkg::sgd_rsp_type got);
      sgd_pkg::sgd_rsp_type want;
      if (pending_gradients.size() == 0) begin
         mismatches++;
         $display("%0t: result expected none actual mag %0d dir %0d last %0d", $time,
                  got.magnitude, got.direction, got.last_of_frame);
         return;
      end
      want = pending_gradients.pop_front();
      if (got.magnitude !== want.magnitude) flag("magnitude", want.magnitude, got.magnitude);
      if (got.direction !== want.direction) flag("direction", want.direction, got.direction);
      if (got.last_of_frame !== want.last_of_frame) begin
         flag("last_of_frame", want.last_of_frame, got.last_of_frame);
      end
   endfunction
endclass

module tb_sobel_gradient_direction;
   import sgd_pkg::*;

   localparam int MAX_SIDE       = 1024;
   localparam int RESET_PIXELS   = 12;
   localparam int RANDOM_ITEMS   = 750;
   localparam int QUIET_ITEMS    = 200;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   // pixel fill patterns for a frame
   localparam int FILL_NOISE  = 0;
   localparam int FILL_BINARY = 1;
   localparam int FILL_RAMP   = 2;
   localparam int FILL_FLAT   = 3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   sgd_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   sgd_rsp_type               rsp_data;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   gradient_scoreboard sobel_check;
   bit                 idling = 1'b1;
   int unsigned        items_sent = 0;
   int unsigned        cur_w = RESET_WIDTH;
   int unsigned        cur_h = RESET_HEIGHT;
   int unsigned        ramp_dx;
   int unsigned        ramp_dy;
   logic [7:0]         flat_level;
   int unsigned        stall_left = 0;
   int unsigned        quiet_cycles = 0;

   sobel_gradient_direction dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   // Result side: check accepted results, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sobel_check.check_gradient(rsp_data);
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 17);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int unsigned clamp_size(int unsigned value);
      if (value == 0) return 1;
      if (value > MAX_SIDE) return MAX_SIDE;
      return value;
   endfunction

   function automatic logic [7:0] pick_pixel(int mode, int unsigned x, int unsigned y);
      int unsigned level;
      case (mode)
         FILL_BINARY: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         FILL_RAMP: begin
            level = x * ramp_dx + y * ramp_dy;
            return level[7:0];
         end
         FILL_FLAT: return flat_level;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one item, with an occasional gap first, and wait for it to be taken
   task automatic send_item(logic [7:0] value, logic is_flush);
      sgd_req_type item;
      item.pixel = value;
      item.flush = is_flush;
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sobel_check.note_pixel_item(item);
   endtask

   // Wait until every expected result is in and the block has gone quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sobel_check.pending_gradients.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      sobel_check.set_register(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Raster pixels with stray early flushes, then the drain items
   task automatic stream_frame(int unsigned pixel_total, int unsigned drain_total, int mode);
      for (int unsigned k = 0; k < pixel_total; k++) begin
         if ($urandom_range(0, 29) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
         send_item(pick_pixel(mode, k % cur_w, k / cur_w), 1'b0);
      end
      for (int unsigned k = 0; k < drain_total; k++) begin
         send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      items_sent += pixel_total + drain_total;
   endtask

   initial begin
      logic [7:0]  corner_img [9];
      int unsigned random_start;
      int unsigned width_val;
      int unsigned height_val;
      int unsigned full;
      int unsigned pix_total;
      int unsigned drain_total;
      int          mode;
      bit          must_restart;

      sobel_check = new();
      corner_img = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
      must_restart = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes: a few pixels of the first row
      cur_w = clamp_size(RESET_WIDTH);
      stream_frame(RESET_PIXELS, 0, FILL_NOISE);

      // 3x3 frame with full-scale edges, a stray flush, pixels mixed into the drain
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 11'd3);
      write_csr(REG_IMAGE_HEIGHT, 11'd3);
      cur_w = 3;
      for (int k = 0; k < 9; k++) begin
         send_item(corner_img[k], 1'b0);
         if (k == 3) send_item(8'd255, 1'b1);
      end
      send_item(8'd0, 1'b1);
      send_item(8'd255, 1'b0);
      send_item(8'd0, 1'b1);
      send_item(8'd0, 1'b1);

      // Zero sizes act as a single pixel frame
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 11'd0);
      write_csr(REG_IMAGE_HEIGHT, 11'd0);
      cur_w = 1;
      send_item(8'd255, 1'b1);
      send_item(8'd255, 1'b0);
      send_item(8'd0, 1'b0);
      send_item(8'd0, 1'b1);

      // Widest row, capped from the largest register value; drain cut short
      wait_idle();
      write_csr(REG_IMAGE_WIDTH, 11'd2047);
      write_csr(REG_IMAGE_HEIGHT, 11'd1);
      cur_w = MAX_SIDE;
      ramp_dx = $urandom_range(1, 40);
      ramp_dy = $urandom_range(1, 40);
      stream_frame(MAX_SIDE, 2, FILL_RAMP);
      must_restart = 1'b1;

      // Random small frames, mostly complete, some cut short
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         idling = (items_sent - random_start < RANDOM_ITEMS - QUIET_ITEMS)
                  && ($urandom_range(0, 3) != 0);
         if (must_restart || $urandom_range(0, 3) != 0) begin
            wait_idle();
            width_val = $urandom_range(0, 99);
            width_val = (width_val < 3) ? 0 :
                        ((width_val < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40));
            height_val = $urandom_range(0, 99);
            height_val = (height_val < 3) ? 0 :
                         ((height_val < 85) ? $urandom_range(1, 5) : $urandom_range(6, 10));
            case ($urandom_range(0, 5))
               0: write_csr(REG_IMAGE_WIDTH, CSR_DATA_BITS'(width_val));
               1: write_csr(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(height_val));
               2: begin
                  write_csr(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(height_val));
                  write_csr(REG_IMAGE_WIDTH, CSR_DATA_BITS'(width_val));
               end
               default: begin
                  write_csr(REG_IMAGE_WIDTH, CSR_DATA_BITS'(width_val));
                  write_csr(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(height_val));
               end
            endcase
            cur_w = clamp_size(sobel_check.width_reg);
            cur_h = clamp_size(sobel_check.height_reg);
            must_restart = 1'b0;
         end
         mode = $urandom_range(FILL_NOISE, FILL_FLAT);
         ramp_dx = $urandom_range(0, 80);
         ramp_dy = $urandom_range(0, 80);
         flat_level = 8'($urandom_range(0, 255));
         full = cur_w * cur_h;
         if ($urandom_range(0, 9) == 0) begin
            pix_total = $urandom_range(0, full);
            drain_total = (pix_total == full) ? $urandom_range(0, cur_w) : 0;
            must_restart = 1'b1;
         end else begin
            pix_total = full;
            drain_total = cur_w + 1;
         end
         stream_frame(pix_total, drain_total, mode);
      end

      // Drain everything, then give stray results time to show up
      idling = 1'b0;
      wait_idle();
      if (sobel_check.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
